// ===== sv/binomial_european_option_pricer_assert.svh =====
// Assertion macros for the binomial option pricer.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BINOMIAL_EUROPEAN_OPTION_PRICER_ASSERT_SVH
`define BINOMIAL_EUROPEAN_OPTION_PRICER_ASSERT_SVH

// condition implies consequence in the same cycle
`define BOP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define BOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bop_pkg.sv =====
// Shared types, constants and fixed-point helpers for the binomial option pricer.
// No dependencies.
package bop_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_UP   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DOWN = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GROW = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PROB = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DISC = 3'd4;

  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [31:0] RST_UP    = 32'h4000_0000;
  localparam logic [31:0] RST_DOWN  = 32'h4000_0000;
  localparam logic [31:0] RST_GROW  = 32'h4000_0000;
  localparam logic [30:0] RST_PROB  = 31'h2000_0000;
  localparam logic [30:0] RST_DISC  = 31'h4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAF_INIT,
    ST_LEAF_MUL,
    ST_LEAF_WR,
    ST_ROW_RD,
    ST_ROW_LDA,
    ST_NODE_RD,
    ST_NODE_MQ,
    ST_NODE_SUM,
    ST_NODE_MD,
    ST_NODE_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic leaf_init;
    logic leaf_mul;
    logic leaf_up;
    logic leaf_wr;
    logic rd_en;
    logic a_from_rd;
    logic mul_p;
    logic mul_q;
    logic sum;
    logic mul_d;
    logic node_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic arb;
    logic out_free;
  } status_t;

  // Q16.16 price times Q2.30 factor, truncated, saturated
  function automatic logic [31:0] scale_price(input logic [31:0] price,
                                              input logic [31:0] factor);
    logic [63:0] prod;
    logic [33:0] sh;
    prod = {32'd0, price} * {32'd0, factor};
    sh   = prod[63:30];
    return (sh[33:32] != 2'd0) ? 32'hFFFF_FFFF : sh[31:0];
  endfunction

endpackage

// ===== sv/bop_ctrl.sv =====
// Sequencer for the binomial pricer: leaf build, backward induction, result hand-off.
// Depends on bop_pkg.
module bop_ctrl import bop_pkg::*; #(
  parameter int unsigned STEPS = 20,
  parameter int unsigned CW    = $clog2(STEPS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  status_t       status,
  output cmd_t          cmd,
  output logic [CW-1:0] rd_addr,
  output logic [CW-1:0] wr_addr
);

  localparam logic [CW:0] STEPS_W = (CW+1)'(STEPS);
  localparam logic [CW-1:0] LAST  = CW'(STEPS - 1);
  localparam logic [CW-1:0] TOP   = CW'(STEPS);

  state_t state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt;     // leaf index, then row index
  logic [CW-1:0] k_r, k_nxt;     // multiply count within a leaf
  logic [CW-1:0] j_r, j_nxt;     // node index within a row
  logic [CW-1:0] lim_r, lim_nxt; // last node of the current row

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
      lim_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      lim_r   <= lim_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    lim_nxt   = lim_r;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        if (in_tvalid) state_nxt = status.arb ? ST_DONE : ST_LEAF_INIT;
      end
      ST_LEAF_INIT: begin
        k_nxt     = '0;
        state_nxt = ST_LEAF_MUL;
      end
      ST_LEAF_MUL: begin
        k_nxt = k_r + 1'b1;
        if (k_r == LAST) state_nxt = ST_LEAF_WR;
      end
      ST_LEAF_WR: begin
        if (i_r == TOP) begin
          i_nxt     = '0;
          lim_nxt   = LAST;
          state_nxt = ST_ROW_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_LEAF_INIT;
        end
      end
      ST_ROW_RD: begin
        j_nxt     = '0;
        state_nxt = ST_ROW_LDA;
      end
      ST_ROW_LDA:  state_nxt = ST_NODE_RD;
      ST_NODE_RD:  state_nxt = ST_NODE_MQ;
      ST_NODE_MQ:  state_nxt = ST_NODE_SUM;
      ST_NODE_SUM: state_nxt = ST_NODE_MD;
      ST_NODE_MD:  state_nxt = ST_NODE_WR;
      ST_NODE_WR: begin
        if (j_r == lim_r) begin
          if (i_r == LAST) begin
            state_nxt = ST_DONE;
          end else begin
            i_nxt     = i_r + 1'b1;
            lim_nxt   = lim_r - 1'b1;
            state_nxt = ST_ROW_RD;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_NODE_RD;
        end
      end
      ST_DONE: if (status.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    rd_addr   = '0;
    wr_addr   = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_LEAF_INIT: cmd.leaf_init = 1'b1;
      ST_LEAF_MUL: begin
        cmd.leaf_mul = 1'b1;
        cmd.leaf_up  = (({1'b0, k_r} + {1'b0, i_r}) < STEPS_W);
      end
      ST_LEAF_WR: begin
        cmd.leaf_wr = 1'b1;
        wr_addr     = i_r;
      end
      ST_ROW_RD:  cmd.rd_en = 1'b1;
      ST_ROW_LDA: cmd.a_from_rd = 1'b1;
      ST_NODE_RD: begin
        cmd.rd_en = 1'b1;
        cmd.mul_p = 1'b1;
        rd_addr   = j_r + 1'b1;
      end
      ST_NODE_MQ:  cmd.mul_q = 1'b1;
      ST_NODE_SUM: cmd.sum = 1'b1;
      ST_NODE_MD:  cmd.mul_d = 1'b1;
      ST_NODE_WR: begin
        cmd.node_wr = 1'b1;
        wr_addr     = j_r;
      end
      ST_DONE: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/bop_dp.sv =====
// Datapath for the binomial pricer: config registers, multipliers, node row, output register.
// Depends on bop_pkg.
module bop_dp import bop_pkg::*; #(
  parameter int unsigned STEPS = 20,
  parameter int unsigned CW    = $clog2(STEPS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_data,
  input  logic [63:0]       in_tdata,
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tuser,
  input  cmd_t              cmd,
  input  logic [CW-1:0]     rd_addr,
  input  logic [CW-1:0]     wr_addr,
  output status_t           status
);

  logic [31:0] up_r, down_r, grow_r;
  logic [30:0] prob_r, disc_r;
  logic [30:0] p_eff, q_eff;

  logic [31:0] s0_r, k_r, s_r, rd_r, a_r, b_r, mix_r, v_r;
  logic        call_r, arb_r;
  logic [62:0] acc_r, prod_r;
  logic [63:0] sum_w;
  logic [62:0] disc_prod;
  logic [31:0] payoff;
  logic [31:0] mem [STEPS+1];
  logic        out_valid_r;
  logic [31:0] out_val_r;
  logic        out_arb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r   <= RST_UP;
      down_r <= RST_DOWN;
      grow_r <= RST_GROW;
      prob_r <= RST_PROB;
      disc_r <= RST_DISC;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_UP:   up_r   <= cfg_data;
        REG_DOWN: down_r <= cfg_data;
        REG_GROW: grow_r <= cfg_data;
        REG_PROB: prob_r <= cfg_data[30:0];
        REG_DISC: disc_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign p_eff = (prob_r > ONE_Q30) ? ONE_Q30 : prob_r;
  assign q_eff = ONE_Q30 - p_eff;

  assign status.arb      = !((down_r != 32'd0) && (down_r < grow_r) && (grow_r < up_r));
  assign status.out_free = !out_valid_r || out_tready;

  assign payoff = call_r ? ((s_r > k_r) ? s_r - k_r : 32'd0)
                         : ((k_r > s_r) ? k_r - s_r : 32'd0);

  assign sum_w     = {1'b0, acc_r} + {1'b0, prod_r};
  assign disc_prod = {31'd0, mix_r} * {32'd0, disc_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s0_r   <= in_tdata[31:0];
      k_r    <= in_tdata[63:32];
      call_r <= in_tuser;
      arb_r  <= status.arb;
    end
    if (cmd.leaf_init) s_r <= s0_r;
    if (cmd.leaf_mul)  s_r <= scale_price(s_r, cmd.leaf_up ? up_r : down_r);
    if (cmd.rd_en)     rd_r <= mem[rd_addr];
    if (cmd.a_from_rd) a_r <= rd_r;
    if (cmd.mul_p)     acc_r <= {31'd0, a_r} * {32'd0, p_eff};
    if (cmd.mul_q) begin
      prod_r <= {31'd0, rd_r} * {32'd0, q_eff};
      b_r    <= rd_r;
    end
    if (cmd.sum)       mix_r <= sum_w[61:30];
    if (cmd.mul_d)     v_r <= disc_prod[62] ? 32'hFFFF_FFFF : disc_prod[61:30];
    if (cmd.node_wr)   a_r <= b_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.leaf_wr)      mem[wr_addr] <= payoff;
    else if (cmd.node_wr) mem[wr_addr] <= v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_val_r <= arb_r ? 32'd0 : v_r;
      out_arb_r <= arb_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_arb_r;

endmodule

// ===== sv/binomial_european_option_pricer.sv =====
// Top level of the binomial European option pricer: sequencer plus datapath.
// Depends on bop_pkg, bop_ctrl, bop_dp and the assertion macro header.
//
//  channel | direction | tdata                              | tuser
//  in_     | sink      | [31:0] spot_price, [63:32] strike  | is_call
//  out_    | source    | [31:0] option_value                | arbitrage
//  cfg_    | write     | cfg_addr index, cfg_data value     | -
//
// An item is accepted, its leaf prices are built by repeated products, backward
// induction runs node by node and row by row, and the result is handed off.
// A one-read, one-write node row serves both the leaf build and the induction.
// When arbitrage is flagged an item goes straight from accept to hand-off.
// Synchronous active-low reset; the next item is taken while a result waits,
// and the hand-off after it stalls until that result has been read.
`include "binomial_european_option_pricer_assert.svh"
module binomial_european_option_pricer import bop_pkg::*; #(
  parameter int unsigned STEPS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // spot_price, strike_price
  input  logic              in_tuser,   // is_call
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // option_value
  output logic              out_tuser   // arbitrage
);

  localparam int unsigned CW = $clog2(STEPS + 1);

  cmd_t          cmd;
  status_t       status;
  logic [CW-1:0] rd_addr, wr_addr;

  bop_ctrl #(.STEPS(STEPS), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  bop_dp #(.STEPS(STEPS), .CW(CW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .status     (status)
  );

  `BOP_ASSERT_NOW(a_arb_zero, out_tvalid && out_tuser, out_tdata == 32'd0, "arbitrage with nonzero value")
  `BOP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready straight after accept")
  `BOP_ASSERT_NOW(a_no_write_idle, in_tready, !(cmd.leaf_wr || cmd.node_wr), "row written while idle")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for binomial_european_option_pricer.
// It keeps its own tree pricer and register copy, drives directed and random
// items under varied back-pressure, and checks every result. Depends on bop_pkg.
module tb;
  import bop_pkg::*;

  localparam int unsigned N_STEPS = 20;
  localparam longint unsigned CYCLE_LIMIT = 8000000;
  localparam logic [31:0] Q30 = 32'h4000_0000;

  typedef struct packed {
    logic [31:0] value;
    logic        arb;
  } price_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tuser;

  logic [31:0] up_f, down_f, grow_f;
  logic [30:0] prob_f, disc_f;
  price_t expected_prices[$];
  int mismatches = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int rcv_hold = 0;
  longint unsigned cycles = 0;

  binomial_european_option_pricer #(.STEPS(N_STEPS)) u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] mul_sat(logic [31:0] price, logic [63:0] factor);
    logic [63:0] prod;
    prod = ({32'd0, price} * factor) >> 30;
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function automatic price_t price_option(logic [31:0] s0, logic [31:0] k, logic call);
    logic [31:0] row[N_STEPS+1];
    logic [31:0] s;
    logic [63:0] p, q, mix;
    price_t r;
    r.value = '0;
    r.arb = 1'b0;
    if (!(down_f > 0 && down_f < grow_f && grow_f < up_f)) begin
      r.arb = 1'b1;
      return r;
    end
    p = (prob_f > Q30) ? 64'(Q30) : 64'(prob_f);
    q = 64'(Q30) - p;
    for (int i = 0; i <= N_STEPS; i++) begin
      s = s0;
      for (int j = 0; j < N_STEPS - i; j++) s = mul_sat(s, 64'(up_f));
      for (int j = 0; j < i; j++) s = mul_sat(s, 64'(down_f));
      if (call) row[i] = (s > k) ? s - k : 32'd0;
      else row[i] = (k > s) ? k - s : 32'd0;
    end
    for (int i = 0; i < N_STEPS; i++)
      for (int j = 0; j < N_STEPS - i; j++) begin
        mix = (p * 64'(row[j]) + q * 64'(row[j+1])) >> 30;
        row[j] = mul_sat(mix[31:0], 64'(disc_f));
      end
    r.value = row[0];
    return r;
  endfunction

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    case (idx)
      REG_UP:   up_f = val;
      REG_DOWN: down_f = val;
      REG_GROW: grow_f = val;
      REG_PROB: prob_f = val[30:0];
      REG_DISC: disc_f = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_factors(logic [31:0] u, logic [31:0] d, logic [31:0] g,
                              logic [31:0] p, logic [31:0] disc);
    write_reg(REG_UP, u);
    write_reg(REG_DOWN, d);
    write_reg(REG_GROW, g);
    write_reg(REG_PROB, p);
    write_reg(REG_DISC, disc);
  endtask

  task automatic send_item(logic [31:0] s0, logic [31:0] k, logic call);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {k, s0};
    in_tuser = call;
    do @(posedge clk); while (!in_tready);
    expected_prices.push_back(price_option(s0, k, call));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (expected_prices.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic realistic_factors();
    logic [31:0] u, d;
    u = Q30 + $urandom_range(32'h0CCC_CCCC, 32'h0010_0000);
    d = Q30 - $urandom_range(32'h0CCC_CCCC, 32'h0010_0000);
    load_factors(u, d, $urandom_range(u - 1, d + 1), $urandom_range(Q30),
                 $urandom_range(Q30, Q30 - 32'h0100_0000));
  endtask

  task automatic random_item();
    logic [31:0] s0, k;
    s0 = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
    k = ($urandom_range(9) == 0) ? $urandom : s0 + $urandom_range(32'h0010_0000) - 32'h0008_0000;
    send_item(s0, k, 1'($urandom_range(1)));
  endtask

  task automatic test_reset_defaults();
    send_item(32'h0064_0000, 32'h0064_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 32'd0, 1'b0);
    drain();
  endtask

  task automatic test_directed_extremes();
    load_factors(32'h4333_3333, 32'h3CF3_CF3D, 32'h4005_0000, 32'h2000_0000, 32'h3FF0_0000);
    send_item(32'd0, 32'd0, 1'b1);
    send_item(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 32'd0, 1'b1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(32'h0064_0000, 32'h0064_0000, 1'b1);
    send_item(32'h0064_0000, 32'h0064_0000, 1'b0);
    drain();
    load_factors(32'hFFFF_FFFF, 32'd1, 32'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h0001_0000, 32'h0000_8000, 1'b1);
    send_item(32'h0001_0000, 32'h0002_0000, 1'b0);
    drain();
    load_factors(32'h4800_0000, 32'h3800_0000, 32'h4100_0000, 32'd0, 32'd0);
    send_item(32'h0064_0000, 32'h0050_0000, 1'b1);
    send_item(32'h0064_0000, 32'h0070_0000, 1'b0);
    drain();
    write_reg(REG_PROB, Q30);
    write_reg(REG_DISC, Q30);
    send_item(32'h0064_0000, 32'h0050_0000, 1'b1);
    drain();
  endtask

  task automatic test_arbitrage_cases();
    load_factors(32'h4800_0000, 32'd0, 32'h4100_0000, 32'h2000_0000, Q30);
    send_item(32'h0064_0000, 32'h0050_0000, 1'b1);
    drain();
    write_reg(REG_DOWN, 32'h4100_0000);
    send_item(32'h0064_0000, 32'h0050_0000, 1'b0);
    drain();
    write_reg(REG_DOWN, 32'h3800_0000);
    write_reg(REG_GROW, 32'h4800_0000);
    send_item(32'h0064_0000, 32'h0050_0000, 1'b1);
    drain();
    // unused register indices must be ignored
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd6, 32'h0000_0000);
    write_reg(3'd7, 32'h1234_5678);
    write_reg(REG_GROW, 32'h4100_0000);
    send_item(32'h0064_0000, 32'h0050_0000, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    realistic_factors();
    snd_idle_pct = 0;
    rcv_hold = 8000;
    repeat (5) random_item();
    drain();
  endtask

  task automatic test_random(int n, int snd_pct, int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        drain();
        if ($urandom_range(5) == 0)
          load_factors($urandom, $urandom, $urandom, $urandom, $urandom);
        else
          realistic_factors();
      end
      random_item();
    end
    drain();
  endtask

  always @(negedge clk) begin
    if (rcv_hold > 0) begin
      out_tready <= 1'b0;
      rcv_hold <= rcv_hold - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    price_t exp_p;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** binomial_european_option_pricer: FAILED **");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_prices.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h arb %b", out_tdata, out_tuser);
      end else begin
        exp_p = expected_prices.pop_front();
        if (out_tdata !== exp_p.value || out_tuser !== exp_p.arb) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %h arb %b, got %h arb %b",
                     exp_p.value, exp_p.arb, out_tdata, out_tuser);
        end
      end
    end
  end

  initial begin
    up_f = RST_UP;
    down_f = RST_DOWN;
    grow_f = RST_GROW;
    prob_f = RST_PROB;
    disc_f = RST_DISC;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_arbitrage_cases();
    test_backpressure();
    test_random(280, 21, 73);
    test_random(280, 73, 21);
    test_random(290, 0, 0);
    repeat (50) @(negedge clk);
    if (mismatches == 0 && expected_prices.size() == 0) begin
      $display("** binomial_european_option_pricer: PASSED **");
    end else begin
      $display("** binomial_european_option_pricer: FAILED **");
    end
    $finish;
  end
endmodule
